// ===== rtl/dhdf_pkg.sv =====
// Package for the datagram header deframer: header layout constants, status codes,
// record type codes and the result record structure. Depends on nothing.
package dhdf_pkg;

   // Header layout.
   localparam int unsigned HEADER_BYTES = 28;
   localparam int unsigned POS_W        = 33;

   // Magic word, sent first byte first.
   localparam logic [7:0] MAGIC_BYTES [4] = '{8'h47, 8'h4C, 8'h4F, 8'h4D};

   // Byte offsets of the header fields.
   localparam logic [4:0] OFS_VERSION_HI = 5'd5;
   localparam logic [4:0] OFS_KIND       = 5'd6;
   localparam logic [4:0] OFS_FLAGS      = 5'd7;
   localparam logic [4:0] OFS_SEQUENCE   = 5'd16;
   localparam logic [4:0] OFS_ACKED      = 5'd20;
   localparam logic [4:0] OFS_LENGTH     = 5'd24;
   localparam logic [4:0] OFS_LAST       = 5'd27;

   // Register indexes of the configuration port.
   localparam logic [7:0] CSR_EXPECTED_VERSION = 8'd0;
   localparam logic [7:0] CSR_PAYLOAD_LIMIT    = 8'd1;
   localparam logic [7:0] CSR_KIND_LOWEST      = 8'd2;
   localparam logic [7:0] CSR_KIND_HIGHEST     = 8'd3;

   // Record type codes.
   localparam logic REC_PAYLOAD = 1'b0;
   localparam logic REC_END     = 1'b1;

   // End record status, in order of the header checks.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_MAGIC     = 3'd2,
      STATUS_VERSION   = 3'd3,
      STATUS_KIND      = 3'd4,
      STATUS_TOO_LARGE = 3'd5,
      STATUS_LENGTH    = 3'd6
   } status_type;

   // One result word.
   typedef struct packed {
      logic        record_type;
      logic [7:0]  payload_data;
      status_type  status;
      logic [7:0]  message_kind;
      logic [7:0]  message_flags;
      logic [63:0] tick_number;
      logic [31:0] sequence_number;
      logic [31:0] acked_number;
      logic [31:0] payload_length;
   } record_type;

endpackage

// ===== rtl/datagram_header_deframer.sv =====
// Datagram header deframer: checks the 28-byte header, forwards payload words and
// emits one end record per datagram. Depends on dhdf_pkg.
//
// The block accepts one datagram byte per cycle while its input is ready and updates
// its byte counter and header shift registers in that same cycle; the results of a
// byte enter a four-word output queue at the same clock edge. A byte yields no word,
// one payload word, one end word, or, for a final payload byte, a payload word
// followed by the end word, which the output side then presents one after the other.
// The input is ready while the queue has room for two words, so with the output
// always ready the block runs at one byte per cycle. Configuration writes are taken
// in any cycle and must be made while no datagram is in progress.
module datagram_header_deframer (
   input  logic        clock,
   input  logic        reset,
   // Byte input.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_datagram,
   // Record output.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_record_type,
   output logic [7:0]  rsp_payload_data,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_message_kind,
   output logic [7:0]  rsp_message_flags,
   output logic [63:0] rsp_tick_number,
   output logic [31:0] rsp_sequence_number,
   output logic [31:0] rsp_acked_number,
   output logic [31:0] rsp_payload_length,
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);
   import dhdf_pkg::*;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers.
   logic [15:0] expected_version_ff;
   logic [31:0] payload_limit_ff;
   logic [7:0]  kind_lowest_ff;
   logic [7:0]  kind_highest_ff;

   // Per-datagram state and its next values.
   logic [POS_W-1:0] pos_ff, pos_in;
   status_type       err_ff, err_in;
   logic [15:0]      version_ff, version_in;
   logic [7:0]       kind_ff, kind_in;
   logic [7:0]       flags_ff, flags_in;
   logic [63:0]      tick_ff, tick_in;
   logic [31:0]      sequence_ff, sequence_in;
   logic [31:0]      acked_ff, acked_in;
   logic [31:0]      length_ff, length_in;

   // Output queue.
   record_type       queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             req_take, rsp_take;
   logic             note_valid;
   status_type       note_code;
   logic [4:0]       hdr_ofs;
   logic             pass_payload;
   logic [1:0]       push_count;
   record_type       payload_rec, end_rec;
   status_type       end_status;

   assign req_ready = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign req_take  = req_valid & req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid & rsp_ready;
   assign csr_ready = 1'b1;
   assign hdr_ofs   = pos_ff[4:0];

   // Header checks and shift register updates for the incoming byte.
   always_comb begin
      pos_in       = pos_ff;
      version_in   = version_ff;
      kind_in      = kind_ff;
      flags_in     = flags_ff;
      tick_in      = tick_ff;
      sequence_in  = sequence_ff;
      acked_in     = acked_ff;
      length_in    = length_ff;
      note_valid   = 1'b0;
      note_code    = STATUS_OK;
      pass_payload = 1'b0;

      if (pos_ff < POS_W'(HEADER_BYTES)) begin
         if (hdr_ofs < OFS_KIND - 5'd2) begin
            if (req_data_byte != MAGIC_BYTES[hdr_ofs[1:0]]) begin
               note_valid = 1'b1;
               note_code  = STATUS_MAGIC;
            end
         end else if (hdr_ofs <= OFS_VERSION_HI) begin
            version_in = {req_data_byte, version_ff[15:8]};
            if (hdr_ofs == OFS_VERSION_HI && version_in != expected_version_ff) begin
               note_valid = 1'b1;
               note_code  = STATUS_VERSION;
            end
         end else if (hdr_ofs == OFS_KIND) begin
            kind_in = req_data_byte;
            if (req_data_byte < kind_lowest_ff || req_data_byte > kind_highest_ff) begin
               note_valid = 1'b1;
               note_code  = STATUS_KIND;
            end
         end else if (hdr_ofs == OFS_FLAGS) begin
            flags_in = req_data_byte;
         end else if (hdr_ofs < OFS_SEQUENCE) begin
            tick_in = {req_data_byte, tick_ff[63:8]};
         end else if (hdr_ofs < OFS_ACKED) begin
            sequence_in = {req_data_byte, sequence_ff[31:8]};
         end else if (hdr_ofs < OFS_LENGTH) begin
            acked_in = {req_data_byte, acked_ff[31:8]};
         end else begin
            length_in = {req_data_byte, length_ff[31:8]};
            if (hdr_ofs == OFS_LAST && length_in > payload_limit_ff) begin
               note_valid = 1'b1;
               note_code  = STATUS_TOO_LARGE;
            end
         end
      end else begin
         // A payload byte past the stated length is a length mismatch.
         if (pos_ff >= POS_W'(HEADER_BYTES) + {1'b0, length_ff}) begin
            note_valid = 1'b1;
            note_code  = STATUS_LENGTH;
         end
      end

      // Only the first error of a datagram is kept.
      err_in = (err_ff == STATUS_OK && note_valid) ? note_code : err_ff;

      if (pos_ff >= POS_W'(HEADER_BYTES)) begin
         pass_payload = (err_in == STATUS_OK);
      end

      // The byte counter saturates at all ones.
      if (pos_ff != '1) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   // Build the payload and end records for this byte, and the queue push count.
   always_comb begin
      payload_rec              = '0;
      payload_rec.record_type  = REC_PAYLOAD;
      payload_rec.payload_data = req_data_byte;

      if (pos_in < POS_W'(HEADER_BYTES)) begin
         end_status = STATUS_SHORT;
      end else if (err_in != STATUS_OK) begin
         end_status = err_in;
      end else if (pos_in != POS_W'(HEADER_BYTES) + {1'b0, length_in}) begin
         end_status = STATUS_LENGTH;
      end else begin
         end_status = STATUS_OK;
      end

      end_rec             = '0;
      end_rec.record_type = REC_END;
      end_rec.status      = end_status;
      if (end_status != STATUS_SHORT) begin
         end_rec.message_kind    = kind_in;
         end_rec.message_flags   = flags_in;
         end_rec.tick_number     = tick_in;
         end_rec.sequence_number = sequence_in;
         end_rec.acked_number    = acked_in;
         end_rec.payload_length  = length_in;
      end

      push_count = 2'(pass_payload) + 2'(req_end_of_datagram);
      if (!req_take) begin
         push_count = 2'd0;
      end
      count_in = count_ff + CNT_W'(push_count) - CNT_W'(rsp_take);
   end

   // Configuration registers, frame state and queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= 16'd1;
         payload_limit_ff    <= 32'd65535;
         kind_lowest_ff      <= 8'd0;
         kind_highest_ff     <= 8'd12;
         pos_ff              <= '0;
         err_ff              <= STATUS_OK;
         version_ff          <= '0;
         kind_ff             <= '0;
         flags_ff            <= '0;
         tick_ff             <= '0;
         sequence_ff         <= '0;
         acked_ff            <= '0;
         length_ff           <= '0;
         wr_ptr_ff           <= '0;
         rd_ptr_ff           <= '0;
         count_ff            <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_EXPECTED_VERSION: expected_version_ff <= csr_data[15:0];
               CSR_PAYLOAD_LIMIT:    payload_limit_ff    <= csr_data;
               CSR_KIND_LOWEST:      kind_lowest_ff      <= csr_data[7:0];
               CSR_KIND_HIGHEST:     kind_highest_ff     <= csr_data[7:0];
               default: ;
            endcase
         end

         if (req_take) begin
            if (req_end_of_datagram) begin
               pos_ff      <= '0;
               err_ff      <= STATUS_OK;
               version_ff  <= '0;
               kind_ff     <= '0;
               flags_ff    <= '0;
               tick_ff     <= '0;
               sequence_ff <= '0;
               acked_ff    <= '0;
               length_ff   <= '0;
            end else begin
               pos_ff      <= pos_in;
               err_ff      <= err_in;
               version_ff  <= version_in;
               kind_ff     <= kind_in;
               flags_ff    <= flags_in;
               tick_ff     <= tick_in;
               sequence_ff <= sequence_in;
               acked_ff    <= acked_in;
               length_ff   <= length_in;
            end
         end

         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_count);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(rsp_take);
         count_ff  <= count_in;
      end
   end

   // Queue storage: a payload word goes first, the end word after it.
   always_ff @(posedge clock) begin
      if (req_take) begin
         if (pass_payload) begin
            queue_ff[wr_ptr_ff] <= payload_rec;
            if (req_end_of_datagram) begin
               queue_ff[wr_ptr_ff + PTR_W'(1)] <= end_rec;
            end
         end else if (req_end_of_datagram) begin
            queue_ff[wr_ptr_ff] <= end_rec;
         end
      end
   end

   // Head of the queue drives the output.
   assign rsp_record_type     = queue_ff[rd_ptr_ff].record_type;
   assign rsp_payload_data    = queue_ff[rd_ptr_ff].payload_data;
   assign rsp_status          = queue_ff[rd_ptr_ff].status;
   assign rsp_message_kind    = queue_ff[rd_ptr_ff].message_kind;
   assign rsp_message_flags   = queue_ff[rd_ptr_ff].message_flags;
   assign rsp_tick_number     = queue_ff[rd_ptr_ff].tick_number;
   assign rsp_sequence_number = queue_ff[rd_ptr_ff].sequence_number;
   assign rsp_acked_number    = queue_ff[rd_ptr_ff].acked_number;
   assign rsp_payload_length  = queue_ff[rd_ptr_ff].payload_length;

endmodule
